@@ hw/rtl/fsa_pkg.sv @@
// Shared types, constants and codes of the fit policy segment allocator.
package fsa_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int POOL_UNITS   = 65536;

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int ADDR_W = 16;
  localparam int LEN_W  = 17;
  localparam int CMD_W  = 2;
  localparam int POL_W  = 2;

  localparam int POOL_LIMIT_INT = (POOL_UNITS < 65536) ? POOL_UNITS : 65536;
  localparam logic [LEN_W-1:0] POOL_LIMIT = LEN_W'(POOL_LIMIT_INT);
  localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_SEGMENTS);

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_POOL   = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic              is_free;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  request_size;
    logic [ADDR_W-1:0] address;
  } cmd_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] result_address;
    logic [LEN_W-1:0]  free_units;
  } rsp_t;

endpackage

@@ hw/rtl/fsa_if.sv @@
// Channel interfaces: command input, result output and register write port.
interface fsa_in_if import fsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [LEN_W-1:0]  request_size;
  logic [ADDR_W-1:0] address;
  modport source (output valid, command, request_size, address, input ready);
  modport sink   (input valid, command, request_size, address, output ready);
endinterface

interface fsa_out_if import fsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [ADDR_W-1:0] result_address;
  logic [LEN_W-1:0]  free_units;
  modport source (output valid, status, result_address, free_units, input ready);
  modport sink   (input valid, status, result_address, free_units, output ready);
endinterface

interface fsa_cfg_if import fsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             index;
  logic [LEN_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/fsa_ram.sv @@
// Generic simple dual port RAM with one write port and a registered read port.
module fsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/fsa_engine.sv @@
// Segment table engine: scans the table memory, decides, splits, merges and shifts entries.
module fsa_engine import fsa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [POL_W-1:0] policy,
  input  logic [LEN_W-1:0] pool,
  input  logic             init_req,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             rsp_valid,
  input  logic             rsp_ack,
  output rsp_t             rsp,
  output logic             idle
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_WA, S_WB, S_RESP
  } state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  logic [CNT_W-1:0]   count_r;
  logic [LEN_W-1:0]   free_r;
  logic [CNT_W-1:0]   scan_ptr_r;
  logic               rd_pend_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   pick_idx_r;
  seg_t               pick_r;
  seg_t               prv_r;
  seg_t               last_r;
  seg_t               nxt_r;
  logic               nxt_ok_r;
  logic               grab_r;
  logic [IDX_W-1:0]   sh_src_r;
  logic [IDX_W-1:0]   sh_dst_r;
  logic [IDX_W-1:0]   sh_wdst_r;
  logic [CNT_W-1:0]   sh_left_r;
  logic               sh_up_r;
  logic               sh_pend_r;
  logic [IDX_W-1:0]   wa_idx_r;
  seg_t               wa_seg_r;
  logic [IDX_W-1:0]   wb_idx_r;
  seg_t               wb_seg_r;
  rsp_t               rsp_r;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [SEG_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [SEG_W-1:0]   ram_rdata;

  seg_t               d;
  logic [LEN_W-1:0]   want;
  logic [LEN_W-1:0]   addr_x;
  logic [LEN_W-1:0]   seg_end;
  logic               hit;
  logic               cand;
  logic               better;
  logic [LEN_W-1:0]   rest;
  logic               split;
  logic               alloc_ok;
  logic               free_ok;
  logic               mrg_n;
  logic               mrg_p;
  logic [LEN_W-1:0]   sum_len;
  logic [1:0]         drop_cnt;
  logic [CNT_W-1:0]   pick_c;
  logic [CNT_W-1:0]   up_left;
  logic [CNT_W-1:0]   dn_src;
  logic [CNT_W-1:0]   dn_left;

  fsa_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign d       = seg_t'(ram_rdata);
  assign want    = cmd_r.request_size;
  assign addr_x  = {1'b0, cmd_r.address};
  assign seg_end = {1'b0, d.start} + d.len;
  assign hit     = (addr_x >= {1'b0, d.start}) && (addr_x < seg_end);
  assign cand    = d.is_free && (d.len >= want);
  assign better  = !found_r
                || ((policy == POL_BEST) && (d.len < pick_r.len))
                || ((policy == POL_WORST) && (d.len > pick_r.len));

  assign rest     = pick_r.len - want;
  assign split    = (rest != '0);
  assign alloc_ok = (policy <= POL_WORST) && (want != '0) && (want <= free_r) && found_r
                 && (!split || (count_r != MAX_CNT));
  assign free_ok  = found_r && !pick_r.is_free;
  assign mrg_n    = nxt_ok_r && nxt_r.is_free;
  assign mrg_p    = (pick_idx_r != '0) && prv_r.is_free;
  assign sum_len  = pick_r.len + (mrg_n ? nxt_r.len : '0) + (mrg_p ? prv_r.len : '0);
  assign drop_cnt = {1'b0, mrg_p} + {1'b0, mrg_n};
  assign pick_c   = CNT_W'(pick_idx_r);
  assign up_left  = count_r - CNT_W'(1) - pick_c;
  assign dn_src   = pick_c + CNT_W'(1) + CNT_W'(mrg_n);
  assign dn_left  = count_r - dn_src;

  assign cmd_ready = (state_r == S_IDLE) && !init_req;
  assign idle      = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_RESP);
  assign rsp       = rsp_r;

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = SEG_W'({ {ADDR_W{1'b0}}, pool, 1'b1 });
      end
      S_SCAN: begin
        ram_raddr = scan_ptr_r[IDX_W-1:0];
      end
      S_SHIFT: begin
        ram_raddr = sh_src_r;
        ram_we    = sh_pend_r;
        ram_waddr = sh_wdst_r;
        ram_wdata = ram_rdata;
      end
      S_WA: begin
        ram_we    = 1'b1;
        ram_waddr = wa_idx_r;
        ram_wdata = wa_seg_r;
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = wb_idx_r;
        ram_wdata = wb_seg_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      count_r   <= '0;
      free_r    <= '0;
      rd_pend_r <= 1'b0;
      sh_pend_r <= 1'b0;
      found_r   <= 1'b0;
      grab_r    <= 1'b0;
      nxt_ok_r  <= 1'b0;
    end else begin
      case (state_r)
        S_INIT: begin
          count_r <= CNT_W'(1);
          free_r  <= pool;
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (init_req) begin
            state_r <= S_INIT;
          end else if (cmd_valid) begin
            cmd_r      <= cmd;
            scan_ptr_r <= '0;
            rd_pend_r  <= 1'b0;
            found_r    <= 1'b0;
            grab_r     <= 1'b0;
            nxt_ok_r   <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_ptr_r < count_r) begin
            scan_ptr_r <= scan_ptr_r + CNT_W'(1);
            rd_pend_r  <= 1'b1;
            rd_idx_r   <= scan_ptr_r[IDX_W-1:0];
          end else begin
            rd_pend_r <= 1'b0;
          end
          if (rd_pend_r) begin
            last_r <= d;
            if (cmd_r.command == CMD_ALLOC) begin
              if (cand && better) begin
                found_r    <= 1'b1;
                pick_idx_r <= rd_idx_r;
                pick_r     <= d;
              end
            end else if (hit) begin
              found_r    <= 1'b1;
              pick_idx_r <= rd_idx_r;
              pick_r     <= d;
              prv_r      <= last_r;
              grab_r     <= 1'b1;
            end else if (grab_r) begin
              nxt_r    <= d;
              nxt_ok_r <= 1'b1;
              grab_r   <= 1'b0;
            end
          end
          if ((scan_ptr_r == count_r) && !rd_pend_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          rsp_r.result_address <= '0;
          rsp_r.status         <= 1'b1;
          rsp_r.free_units     <= free_r;
          sh_left_r            <= '0;
          state_r              <= S_RESP;
          case (cmd_r.command)
            CMD_ALLOC: begin
              if (alloc_ok) begin
                free_r               <= free_r - want;
                rsp_r.status         <= 1'b0;
                rsp_r.result_address <= pick_r.start;
                rsp_r.free_units     <= free_r - want;
                wb_idx_r             <= pick_idx_r;
                wb_seg_r             <= '{start: pick_r.start, len: want, is_free: 1'b0};
                if (split) begin
                  count_r   <= count_r + CNT_W'(1);
                  wa_idx_r  <= pick_idx_r + IDX_W'(1);
                  wa_seg_r  <= '{start: pick_r.start + want[ADDR_W-1:0], len: rest,
                                 is_free: 1'b1};
                  sh_up_r   <= 1'b1;
                  sh_src_r  <= IDX_W'(count_r - CNT_W'(1));
                  sh_dst_r  <= IDX_W'(count_r);
                  sh_left_r <= up_left;
                  state_r   <= S_SHIFT;
                end else begin
                  state_r <= S_WB;
                end
              end
            end
            CMD_FREE: begin
              if (free_ok) begin
                free_r           <= free_r + pick_r.len;
                rsp_r.status     <= 1'b0;
                rsp_r.free_units <= free_r + pick_r.len;
                wb_idx_r         <= mrg_p ? pick_idx_r - IDX_W'(1) : pick_idx_r;
                wb_seg_r         <= '{start: (mrg_p ? prv_r.start : pick_r.start),
                                      len: sum_len, is_free: 1'b1};
                count_r          <= count_r - CNT_W'(drop_cnt);
                sh_up_r          <= 1'b0;
                sh_src_r         <= IDX_W'(dn_src);
                sh_dst_r         <= IDX_W'(dn_src - CNT_W'(drop_cnt));
                sh_left_r        <= dn_left;
                state_r          <= S_WB;
              end
            end
            CMD_CHECK: begin
              rsp_r.status <= !(found_r && !pick_r.is_free);
            end
            default: ;
          endcase
        end
        S_SHIFT: begin
          // read one entry per cycle, write it to its new slot in the next cycle
          if (sh_left_r != '0) begin
            sh_pend_r <= 1'b1;
            sh_wdst_r <= sh_dst_r;
            sh_left_r <= sh_left_r - CNT_W'(1);
            if (sh_up_r) begin
              sh_src_r <= sh_src_r - IDX_W'(1);
              sh_dst_r <= sh_dst_r - IDX_W'(1);
            end else begin
              sh_src_r <= sh_src_r + IDX_W'(1);
              sh_dst_r <= sh_dst_r + IDX_W'(1);
            end
          end else begin
            sh_pend_r <= 1'b0;
            if (!sh_pend_r) begin
              state_r <= sh_up_r ? S_WA : S_RESP;
            end
          end
        end
        S_WA: begin
          state_r <= S_WB;
        end
        S_WB: begin
          if ((cmd_r.command == CMD_FREE) && (sh_left_r != '0)) begin
            state_r <= S_SHIFT;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (rsp_ack) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/fit_policy_segment_allocator.sv @@
// Top level: allocator with first, best or worst fit over a segment table memory.
// Each command scans the table (one table read a cycle), then decides; an alloc writes
// its entry, a split first shifts any later entries up one slot and writes the free rest,
// a successful free writes the merged segment, then shifts any later entries down.
// One command at a time: the next is accepted after the result is taken for output.
// Reset and every pool_size write set up the single free segment in an init state.
module fit_policy_segment_allocator import fsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fsa_in_if.sink    in_s,
  fsa_out_if.source out_s,
  fsa_cfg_if.sink   cfg_s
);

  logic [POL_W-1:0] policy_r;
  logic [LEN_W-1:0] pool_r;
  logic [LEN_W-1:0] pool_nxt;
  logic             out_valid_r;
  rsp_t             out_r;

  logic             eng_idle;
  logic             cfg_xfer;
  logic             init_req;
  logic             rsp_valid;
  logic             rsp_ack;
  rsp_t             rsp;
  cmd_t             cmd;

  assign cfg_s.ready = eng_idle;
  assign cfg_xfer    = cfg_s.valid && cfg_s.ready;
  assign init_req    = cfg_xfer && (cfg_s.index == REG_POOL);

  // clamp the pool size into its legal range
  always_comb begin
    pool_nxt = cfg_s.data;
    if (cfg_s.data == '0) begin
      pool_nxt = LEN_W'(1);
    end else if (cfg_s.data > POOL_LIMIT) begin
      pool_nxt = POOL_LIMIT;
    end
  end

  assign cmd.command      = in_s.command;
  assign cmd.request_size = in_s.request_size;
  assign cmd.address      = in_s.address;

  fsa_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .policy    (policy_r),
    .pool      (pool_r),
    .init_req  (init_req),
    .cmd_valid (in_s.valid),
    .cmd_ready (in_s.ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ack   (rsp_ack),
    .rsp       (rsp),
    .idle      (eng_idle)
  );

  assign rsp_ack = rsp_valid && (!out_valid_r || out_s.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_FIRST;
      pool_r      <= POOL_LIMIT;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        if (cfg_s.index == REG_POLICY) begin
          policy_r <= cfg_s.data[POL_W-1:0];
        end else begin
          pool_r <= pool_nxt;
        end
      end
      if (rsp_ack) begin
        out_valid_r <= 1'b1;
        out_r       <= rsp;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_s.valid          = out_valid_r;
  assign out_s.status         = out_r.status;
  assign out_s.result_address = out_r.result_address;
  assign out_s.free_units     = out_r.free_units;

endmodule
